FILE: design/trpd_pkg.sv
// ----------------------------------------------------------------------------
// trpd_pkg
// Shared codes, types and helpers for the run-length pixel decoder.
// ----------------------------------------------------------------------------
package trpd_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    // input opcodes
    localparam logic [1:0] OP_STREAM    = 2'd0;
    localparam logic [1:0] OP_PAL_WRITE = 2'd1;
    localparam logic [1:0] OP_RESTART   = 2'd2;

    // pixel formats
    localparam logic [2:0] FMT_INDEXED8  = 3'd0;
    localparam logic [2:0] FMT_RGB555    = 3'd1;
    localparam logic [2:0] FMT_BGR24     = 3'd2;
    localparam logic [2:0] FMT_BGRA32    = 3'd3;
    localparam logic [2:0] FMT_GRAY8     = 3'd4;
    localparam logic [2:0] FMT_GRAY_A16  = 3'd5;

    // configuration register indexes
    localparam logic [1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [2:0]  format;
        logic [31:0] total;
    } cfg_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       last_pixel;
        logic       run_clipped;
    } pix_t;

    typedef struct packed {
        logic use_pal;
        logic pal_zero;
        pix_t pix;
    } stage_t;

    function automatic logic [2:0] bytes_per_pixel(input logic [2:0] fmt);
        logic [2:0] n;
        unique case (fmt)
            FMT_INDEXED8, FMT_GRAY8:  n = 3'd1;
            FMT_RGB555, FMT_GRAY_A16: n = 3'd2;
            FMT_BGRA32:               n = 3'd4;
            default:                  n = 3'd3;
        endcase
        return n;
    endfunction

endpackage

FILE: design/trpd_cfg.sv
// ----------------------------------------------------------------------------
// trpd_cfg
// Configuration registers and the registered pixel total of the image.
// ----------------------------------------------------------------------------
module trpd_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [1:0]       wr_index,
    input  logic [15:0]      wr_data,
    output trpd_pkg::cfg_t   cfg
);

    logic [2:0]  format_reg;
    logic [15:0] width_reg;
    logic [15:0] height_reg;
    logic [31:0] total_reg;
    logic [31:0] product;

    always_comb
    begin
        if (wr_index == trpd_pkg::CFG_IMAGE_WIDTH)
        begin
            product = {16'd0, wr_data} * {16'd0, height_reg};
        end
        else
        begin
            product = {16'd0, width_reg} * {16'd0, wr_data};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            format_reg <= trpd_pkg::FMT_BGR24;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            total_reg  <= 32'd1;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                trpd_pkg::CFG_PIXEL_FORMAT:
                begin
                    format_reg <= wr_data[2:0];
                end
                trpd_pkg::CFG_IMAGE_WIDTH:
                begin
                    width_reg <= wr_data;
                    total_reg <= (product == 32'd0) ? 32'd1 : product;
                end
                trpd_pkg::CFG_IMAGE_HEIGHT:
                begin
                    height_reg <= wr_data;
                    total_reg  <= (product == 32'd0) ? 32'd1 : product;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.format = format_reg;
    assign cfg.total  = total_reg;

endmodule

FILE: design/trpd_palette.sv
// ----------------------------------------------------------------------------
// trpd_palette
// Palette memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module trpd_palette (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [trpd_pkg::PAL_AW-1:0] wr_addr,
    input  logic [23:0]                wr_data,
    input  logic                       rd_en,
    input  logic [trpd_pkg::PAL_AW-1:0] rd_addr,
    output logic [23:0]                rd_data
);

    logic [23:0] palette_mem [trpd_pkg::PALETTE_DEPTH];
    logic [23:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            palette_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= palette_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/trpd_parser.sv
// ----------------------------------------------------------------------------
// trpd_parser
// Packet and pixel state; turns each accepted byte into at most one pixel.
// ----------------------------------------------------------------------------
module trpd_parser (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        fire,
    input  logic [1:0]                  opcode,
    input  logic [7:0]                  data_byte,
    input  trpd_pkg::cfg_t              cfg,
    input  logic                        push,
    output logic                        stage_valid,
    output trpd_pkg::stage_t            stage,
    output logic [trpd_pkg::PAL_AW-1:0] pal_rd_addr
);

    logic        expect_hdr_reg, expect_hdr_next;
    logic        is_repeat_reg, is_repeat_next;
    logic [7:0]  pkt_left_reg, pkt_left_next;
    logic [1:0]  byte_idx_reg, byte_idx_next;
    logic [31:0] asm_reg, asm_next;
    logic [31:0] img_left_reg, img_left_next;
    logic        clipped_reg, clipped_next;
    logic        valid_reg, valid_next;
    trpd_pkg::stage_t stage_reg, stage_next;

    logic [31:0] asm_new;
    logic [2:0]  idx_inc;
    logic [7:0]  hdr_count;
    logic [31:0] img_eff;
    logic        hdr_clip;
    logic [7:0]  used;
    logic [31:0] img_rem;
    logic [7:0]  b0, b1, b2, b3;
    logic [15:0] c555;
    logic        produce;

    always_comb
    begin
        unique case (byte_idx_reg)
            2'd0:    asm_new = asm_reg | {24'd0, data_byte};
            2'd1:    asm_new = asm_reg | {16'd0, data_byte, 8'd0};
            2'd2:    asm_new = asm_reg | {8'd0, data_byte, 16'd0};
            default: asm_new = asm_reg | {data_byte, 24'd0};
        endcase
        b0      = asm_new[7:0];
        b1      = asm_new[15:8];
        b2      = asm_new[23:16];
        b3      = asm_new[31:24];
        c555    = asm_new[15:0];
        idx_inc = {1'b0, byte_idx_reg} + 3'd1;

        hdr_count = {1'b0, data_byte[6:0]} + 8'd1;
        img_eff   = (img_left_reg == 32'd0) ? cfg.total : img_left_reg;
        hdr_clip  = {24'd0, hdr_count} > img_eff;

        used    = is_repeat_reg ? pkt_left_reg : 8'd1;
        img_rem = ({24'd0, used} >= img_left_reg) ? 32'd0 : img_left_reg - {24'd0, used};

        expect_hdr_next = expect_hdr_reg;
        is_repeat_next  = is_repeat_reg;
        pkt_left_next   = pkt_left_reg;
        byte_idx_next   = byte_idx_reg;
        asm_next        = asm_reg;
        img_left_next   = img_left_reg;
        clipped_next    = clipped_reg;
        stage_next      = stage_reg;
        produce         = 1'b0;

        // pixel conversion, file byte order
        stage_next.use_pal  = 1'b0;
        stage_next.pal_zero = {1'b0, b0} >= 9'(trpd_pkg::PALETTE_DEPTH);
        stage_next.pix.alpha = trpd_pkg::ALPHA_OPAQUE;
        unique case (cfg.format)
            trpd_pkg::FMT_INDEXED8:
            begin
                stage_next.use_pal   = 1'b1;
                stage_next.pix.blue  = 8'd0;
                stage_next.pix.green = 8'd0;
                stage_next.pix.red   = 8'd0;
            end
            trpd_pkg::FMT_RGB555:
            begin
                stage_next.pix.red   = {c555[14:10], 3'd0};
                stage_next.pix.green = {c555[9:5], 3'd0};
                stage_next.pix.blue  = {c555[4:0], 3'd0};
            end
            trpd_pkg::FMT_BGRA32:
            begin
                stage_next.pix.blue  = b0;
                stage_next.pix.green = b1;
                stage_next.pix.red   = b2;
                stage_next.pix.alpha = b3;
            end
            trpd_pkg::FMT_GRAY8:
            begin
                stage_next.pix.blue  = b0;
                stage_next.pix.green = b0;
                stage_next.pix.red   = b0;
            end
            trpd_pkg::FMT_GRAY_A16:
            begin
                stage_next.pix.blue  = b0;
                stage_next.pix.green = b0;
                stage_next.pix.red   = b0;
                stage_next.pix.alpha = b1;
            end
            default:
            begin
                stage_next.pix.blue  = b0;
                stage_next.pix.green = b1;
                stage_next.pix.red   = b2;
            end
        endcase
        stage_next.pix.repeat_count = used;
        stage_next.pix.last_pixel   = (img_rem == 32'd0);
        stage_next.pix.run_clipped  = clipped_reg;

        if (fire)
        begin
            case (opcode)
                trpd_pkg::OP_RESTART:
                begin
                    expect_hdr_next = 1'b1;
                    is_repeat_next  = 1'b0;
                    pkt_left_next   = 8'd0;
                    byte_idx_next   = 2'd0;
                    asm_next        = 32'd0;
                    clipped_next    = 1'b0;
                    img_left_next   = cfg.total;
                end
                trpd_pkg::OP_STREAM:
                begin
                    if (expect_hdr_reg)
                    begin
                        img_left_next   = img_eff;
                        clipped_next    = hdr_clip;
                        pkt_left_next   = hdr_clip ? img_eff[7:0] : hdr_count;
                        is_repeat_next  = data_byte[7];
                        byte_idx_next   = 2'd0;
                        asm_next        = 32'd0;
                        expect_hdr_next = 1'b0;
                    end
                    else if (idx_inc < trpd_pkg::bytes_per_pixel(cfg.format))
                    begin
                        asm_next      = asm_new;
                        byte_idx_next = idx_inc[1:0];
                    end
                    else
                    begin
                        produce       = 1'b1;
                        asm_next      = 32'd0;
                        byte_idx_next = 2'd0;
                        pkt_left_next = pkt_left_reg - used;
                        img_left_next = img_rem;
                        if (img_rem == 32'd0)
                        begin
                            expect_hdr_next = 1'b1;
                            is_repeat_next  = 1'b0;
                            pkt_left_next   = 8'd0;
                            clipped_next    = 1'b0;
                        end
                        else if (pkt_left_reg == used)
                        begin
                            expect_hdr_next = 1'b1;
                            clipped_next    = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (fire)
        begin
            valid_next = produce;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_hdr_reg <= 1'b1;
            is_repeat_reg  <= 1'b0;
            pkt_left_reg   <= 8'd0;
            byte_idx_reg   <= 2'd0;
            asm_reg        <= 32'd0;
            img_left_reg   <= 32'd0;
            clipped_reg    <= 1'b0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            expect_hdr_reg <= expect_hdr_next;
            is_repeat_reg  <= is_repeat_next;
            pkt_left_reg   <= pkt_left_next;
            byte_idx_reg   <= byte_idx_next;
            asm_reg        <= asm_next;
            img_left_reg   <= img_left_next;
            clipped_reg    <= clipped_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && produce)
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_valid = valid_reg;
    assign stage       = stage_reg;
    assign pal_rd_addr = asm_new[trpd_pkg::PAL_AW-1:0];

endmodule

FILE: design/trpd_out_queue.sv
// ----------------------------------------------------------------------------
// trpd_out_queue
// Two-entry result queue between the decoder and the output channel.
// ----------------------------------------------------------------------------
module trpd_out_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  trpd_pkg::pix_t push_data,
    output logic           can_push,
    output logic           out_valid,
    input  logic           out_ready,
    output trpd_pkg::pix_t out_data
);

    trpd_pkg::pix_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       pop;

    assign out_valid = (count_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    assign can_push  = (count_reg != 2'd2) || out_ready;
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/targa_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// targa_rle_pixel_decoder
// Run-length image stream decoder producing one result per completed pixel.
//
// Input channel (in_valid/in_ready): one transfer per cycle carries an opcode:
// a stream byte, a palette entry write or a restart of the image decode.
// Output channel (out_valid/out_ready): one transfer per decoded pixel with
// blue, green, red, alpha, repeat count, last and clipped flags.
// Configuration channel (cfg_valid/cfg_ready): always ready; users write it
// only while the decoder is idle, not enforced by the block; the pixel total
// is registered on the write. Throughput: one input transfer per cycle while
// in_ready is high, set by the single parser stage. Path: the byte completing
// a pixel loads the parser stage and palette read registers together; the
// merged result then enters the output queue, where it becomes visible.
// Stall: a two-entry output queue keeps input transfers flowing while one
// result waits; input stalls only when the queue is full and a further
// result is pending.
// Reset: stream state cleared, header expected, format bgr24, 1x1 image;
// the palette holds no defined contents until written.
// ----------------------------------------------------------------------------
module targa_rle_pixel_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [7:0]  data_byte,
    input  logic [7:0]  palette_index,
    input  logic [23:0] palette_color,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  blue,
    output logic [7:0]  green,
    output logic [7:0]  red,
    output logic [7:0]  alpha,
    output logic [7:0]  repeat_count,
    output logic        last_pixel,
    output logic        run_clipped,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    trpd_pkg::cfg_t   cfg;
    trpd_pkg::stage_t stage;
    trpd_pkg::pix_t   push_data;
    trpd_pkg::pix_t   out_data;
    logic             stage_valid;
    logic             in_fire;
    logic             push;
    logic             can_push;
    logic             pal_we;
    logic [23:0]      pal_q;
    logic [trpd_pkg::PAL_AW-1:0] pal_rd_addr;

    assign cfg_ready = 1'b1;
    assign in_ready  = !stage_valid || can_push;
    assign in_fire   = in_valid && in_ready;
    assign push      = stage_valid && can_push;
    assign pal_we    = in_fire && (opcode == trpd_pkg::OP_PAL_WRITE)
                       && ({1'b0, palette_index} < 9'(trpd_pkg::PALETTE_DEPTH));

    trpd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    trpd_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (in_fire),
        .opcode      (opcode),
        .data_byte   (data_byte),
        .cfg         (cfg),
        .push        (push),
        .stage_valid (stage_valid),
        .stage       (stage),
        .pal_rd_addr (pal_rd_addr)
    );

    trpd_palette u_palette (
        .clk     (clk),
        .wr_en   (pal_we),
        .wr_addr (palette_index[trpd_pkg::PAL_AW-1:0]),
        .wr_data (palette_color),
        .rd_en   (in_fire),
        .rd_addr (pal_rd_addr),
        .rd_data (pal_q)
    );

    // palette lookup result merged in as the pixel leaves the parser stage
    always_comb
    begin
        push_data = stage.pix;
        if (stage.use_pal)
        begin
            push_data.blue  = stage.pal_zero ? 8'd0 : pal_q[7:0];
            push_data.green = stage.pal_zero ? 8'd0 : pal_q[15:8];
            push_data.red   = stage.pal_zero ? 8'd0 : pal_q[23:16];
        end
    end

    trpd_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign blue         = out_data.blue;
    assign green        = out_data.green;
    assign red          = out_data.red;
    assign alpha        = out_data.alpha;
    assign repeat_count = out_data.repeat_count;
    assign last_pixel   = out_data.last_pixel;
    assign run_clipped  = out_data.run_clipped;

    a_restart_no_result : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && opcode == trpd_pkg::OP_RESTART) |=> !stage_valid)
        else $error("restart produced a pending pixel");

    a_palette_no_result : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && opcode == trpd_pkg::OP_PAL_WRITE) |=> !stage_valid)
        else $error("palette write produced a pending pixel");

    a_count_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (repeat_count != 8'd0))
        else $error("result with zero repeat count");

    a_pending_held : assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && !can_push) |=> (stage_valid && $stable(stage)))
        else $error("pending pixel lost while queue full");

endmodule

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the run-length pixel decoder. A directed table covers
// reset behaviour, field extremes, every opcode, zero dimensions and run
// clipping; randomised phases then sweep all pixel formats and image sizes
// under varied handshake pressure. Every accepted input transfer is run
// through a local decoder model, and each output transfer is checked field by
// field against the oldest predicted pixel.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [2:0] FMT_SPARE6 = 3'd6;
    localparam logic [2:0] FMT_SPARE7 = 3'd7;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int N_PHASES        = 16;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int N_DIRECTED      = 32;
    localparam int LONG_HOLD       = 300;

    localparam logic [2:0] PHASE_FORMATS [8] = '{trpd_pkg::FMT_INDEXED8,
        trpd_pkg::FMT_RGB555, trpd_pkg::FMT_BGR24, trpd_pkg::FMT_BGRA32,
        trpd_pkg::FMT_GRAY8, trpd_pkg::FMT_GRAY_A16, FMT_SPARE6, FMT_SPARE7};

    typedef struct packed {
        logic [1:0]  opcode;
        logic [7:0]  data_byte;
        logic [7:0]  pal_index;
        logic [23:0] pal_color;
    } item_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t       kind;
        logic [1:0]      code;
        logic [23:0]     value;
        logic [7:0]      pal_index;
        bit              typed;
        trpd_pkg::pix_t  want;
    } dir_row_t;

    localparam trpd_pkg::pix_t NO_PIXEL = '0;

    localparam dir_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        // reset state: bgr24, 1x1 image, long repeat run cut to one pixel
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h0000FF, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h000000, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h000000, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h0000FF, 8'h00, 1'b1,
            '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'd1, 1'b1, 1'b1}},
        '{ROW_CFG, trpd_pkg::CFG_PIXEL_FORMAT, {21'd0, trpd_pkg::FMT_BGRA32},
            8'h00, 1'b0, NO_PIXEL},
        '{ROW_CFG, trpd_pkg::CFG_IMAGE_WIDTH, 24'h00FFFF, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_CFG, trpd_pkg::CFG_IMAGE_HEIGHT, 24'h00FFFF, 8'h00, 1'b0, NO_PIXEL},
        // largest image, literal run of 128
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h00007F, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h0000FF, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h0000FF, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h0000FF, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h000000, 8'h00, 1'b1,
            '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'd1, 1'b0, 1'b0}},
        // zero width counts as a one-pixel image
        '{ROW_CFG, trpd_pkg::CFG_PIXEL_FORMAT, {21'd0, trpd_pkg::FMT_RGB555},
            8'h00, 1'b0, NO_PIXEL},
        '{ROW_CFG, trpd_pkg::CFG_IMAGE_WIDTH, 24'h000000, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_RESTART, 24'h000000, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h000080, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h0000FF, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h00007F, 8'h00, 1'b1,
            '{8'hF8, 8'hF8, 8'hF8, 8'hFF, 8'd1, 1'b1, 1'b0}},
        // palette lookups of the first and last entries
        '{ROW_CFG, trpd_pkg::CFG_PIXEL_FORMAT, {21'd0, trpd_pkg::FMT_INDEXED8},
            8'h00, 1'b0, NO_PIXEL},
        '{ROW_CFG, trpd_pkg::CFG_IMAGE_WIDTH, 24'h000002, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_CFG, trpd_pkg::CFG_IMAGE_HEIGHT, 24'h000001, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_PAL_WRITE, 24'hFFFFFF, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_PAL_WRITE, 24'h0000FF, 8'hFF, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h000001, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h0000FF, 8'h00, 1'b1,
            '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'd1, 1'b0, 1'b0}},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h000000, 8'h00, 1'b1,
            '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd1, 1'b1, 1'b0}},
        '{ROW_ITEM, OP_UNUSED, 24'h000000, 8'h00, 1'b0, NO_PIXEL},
        // gray plus alpha repeat run
        '{ROW_CFG, trpd_pkg::CFG_PIXEL_FORMAT, {21'd0, trpd_pkg::FMT_GRAY_A16},
            8'h00, 1'b0, NO_PIXEL},
        '{ROW_CFG, trpd_pkg::CFG_IMAGE_HEIGHT, 24'h000002, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h000081, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h000040, 8'h00, 1'b0, NO_PIXEL},
        '{ROW_ITEM, trpd_pkg::OP_STREAM, 24'h0000C0, 8'h00, 1'b0, NO_PIXEL}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [7:0]  repeat_count;
    logic        last_pixel;
    logic        run_clipped;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // decoder model state
    logic [2:0]  cur_format;
    logic [15:0] cur_width;
    logic [15:0] cur_height;
    logic        await_header;
    logic        run_is_repeat;
    logic [7:0]  run_pixels_left;
    logic [2:0]  pixel_bytes_seen;
    logic [31:0] pixel_word;
    logic [31:0] image_left;
    logic        run_cut;
    logic [23:0] colour_table [trpd_pkg::PALETTE_DEPTH];

    trpd_pkg::pix_t expected_pixels [$];
    int             mismatch_count  = 0;
    int             cycle_count     = 0;
    int unsigned    send_idle_pct   = 0;
    int unsigned    stall_pct       = 0;
    int             hold_off_cycles = 0;

    targa_rle_pixel_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .data_byte     (data_byte),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .blue          (blue),
        .green         (green),
        .red           (red),
        .alpha         (alpha),
        .repeat_count  (repeat_count),
        .last_pixel    (last_pixel),
        .run_clipped   (run_clipped),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout", $time);
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [31:0] image_total();
        logic [31:0] t;
        t = {16'd0, cur_width} * {16'd0, cur_height};
        return (t == 32'd0) ? 32'd1 : t;
    endfunction

    function automatic void clear_stream();
        await_header     = 1'b1;
        run_is_repeat    = 1'b0;
        run_pixels_left  = 8'd0;
        pixel_bytes_seen = 3'd0;
        pixel_word       = 32'd0;
        run_cut          = 1'b0;
    endfunction

    // advances the model by one input transfer; returns 1 when a pixel comes out
    function automatic bit decode_item(input item_t it, output trpd_pkg::pix_t res);
        logic [31:0] count;
        logic [31:0] used;
        logic [2:0]  need;
        logic [7:0]  b0, b1, b2, b3;
        logic [15:0] word555;
        logic [23:0] entry;
        res = '0;
        if (it.opcode == trpd_pkg::OP_PAL_WRITE)
        begin
            colour_table[it.pal_index] = it.pal_color;
            return 1'b0;
        end
        if (it.opcode == trpd_pkg::OP_RESTART)
        begin
            clear_stream();
            image_left = image_total();
            return 1'b0;
        end
        if (it.opcode != trpd_pkg::OP_STREAM)
            return 1'b0;

        if (await_header)
        begin
            count = {25'd0, it.data_byte[6:0]} + 32'd1;
            if (image_left == 32'd0)
                image_left = image_total();
            run_cut = 1'b0;
            if (count > image_left)
            begin
                count   = image_left;
                run_cut = 1'b1;
            end
            run_is_repeat    = it.data_byte[7];
            run_pixels_left  = count[7:0];
            pixel_bytes_seen = 3'd0;
            pixel_word       = 32'd0;
            await_header     = 1'b0;
            return 1'b0;
        end

        pixel_word       = pixel_word | ({24'd0, it.data_byte} << (8 * pixel_bytes_seen[1:0]));
        pixel_bytes_seen = pixel_bytes_seen + 3'd1;
        case (cur_format)
            trpd_pkg::FMT_INDEXED8, trpd_pkg::FMT_GRAY8:  need = 3'd1;
            trpd_pkg::FMT_RGB555, trpd_pkg::FMT_GRAY_A16: need = 3'd2;
            trpd_pkg::FMT_BGRA32:                         need = 3'd4;
            default:                                      need = 3'd3;
        endcase
        if (pixel_bytes_seen < need)
            return 1'b0;

        {b3, b2, b1, b0} = pixel_word;
        word555   = {b1, b0};
        res.alpha = trpd_pkg::ALPHA_OPAQUE;
        case (cur_format)
            trpd_pkg::FMT_INDEXED8:
            begin
                entry     = colour_table[b0];
                res.blue  = entry[7:0];
                res.green = entry[15:8];
                res.red   = entry[23:16];
            end
            trpd_pkg::FMT_RGB555:
            begin
                res.red   = {word555[14:10], 3'b000};
                res.green = {word555[9:5], 3'b000};
                res.blue  = {word555[4:0], 3'b000};
            end
            trpd_pkg::FMT_BGRA32:
            begin
                res.blue  = b0;
                res.green = b1;
                res.red   = b2;
                res.alpha = b3;
            end
            trpd_pkg::FMT_GRAY8:
            begin
                res.blue  = b0;
                res.green = b0;
                res.red   = b0;
            end
            trpd_pkg::FMT_GRAY_A16:
            begin
                res.blue  = b0;
                res.green = b0;
                res.red   = b0;
                res.alpha = b1;
            end
            default:
            begin
                res.blue  = b0;
                res.green = b1;
                res.red   = b2;
            end
        endcase

        used             = run_is_repeat ? {24'd0, run_pixels_left} : 32'd1;
        pixel_bytes_seen = 3'd0;
        pixel_word       = 32'd0;
        run_pixels_left  = run_pixels_left - used[7:0];
        image_left       = (used >= image_left) ? 32'd0 : image_left - used;
        res.repeat_count = used[7:0];
        res.last_pixel   = (image_left == 32'd0);
        res.run_clipped  = run_cut;
        if (image_left == 32'd0)
            clear_stream();
        else if (run_pixels_left == 8'd0)
        begin
            await_header = 1'b1;
            run_cut      = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // output side: check each transfer, then choose next ready
    always @(posedge clk)
    begin
        trpd_pkg::pix_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: pixel expected none, got b %0d g %0d r %0d a %0d n %0d",
                         $time, blue, green, red, alpha, repeat_count);
                mismatch_count++;
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("blue", want.blue, blue);
                check_field("green", want.green, green);
                check_field("red", want.red, red);
                check_field("alpha", want.alpha, alpha);
                check_field("repeat_count", want.repeat_count, repeat_count);
                check_field("last_pixel", {7'd0, want.last_pixel}, {7'd0, last_pixel});
                check_field("run_clipped", {7'd0, want.run_clipped}, {7'd0, run_clipped});
            end
        end
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles = hold_off_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic wait_idle();
        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] index, input logic [15:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (index)
            trpd_pkg::CFG_PIXEL_FORMAT: cur_format = value[2:0];
            trpd_pkg::CFG_IMAGE_WIDTH:  cur_width  = value;
            trpd_pkg::CFG_IMAGE_HEIGHT: cur_height = value;
            default: ;
        endcase
    endtask

    task automatic put_item(input item_t it, input bit typed, input trpd_pkg::pix_t want);
        trpd_pkg::pix_t got;
        bit             has_pixel;
        cfg_valid <= 1'b0;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        opcode        <= it.opcode;
        data_byte     <= it.data_byte;
        palette_index <= it.pal_index;
        palette_color <= it.pal_color;
        do @(posedge clk); while (!in_ready);
        has_pixel = decode_item(it, got);
        if (has_pixel)
            expected_pixels.push_back(typed ? want : got);
    endtask

    initial
    begin
        item_t       it;
        dir_row_t    row;
        logic [15:0] wid;
        logic [15:0] hgt;
        int unsigned roll;
        int          phase;
        int          n;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = trpd_pkg::OP_STREAM;
        data_byte     = 8'd0;
        palette_index = 8'd0;
        palette_color = 24'd0;
        out_ready     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = trpd_pkg::CFG_PIXEL_FORMAT;
        cfg_data      = 16'd0;

        cur_format = trpd_pkg::FMT_BGR24;
        cur_width  = 16'd1;
        cur_height = 16'd1;
        clear_stream();
        image_left = 32'd0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 35;
        stall_pct     = 35;
        for (n = 0; n < N_DIRECTED; n++)
        begin
            row = DIRECTED_ROWS[n];
            if (row.kind == ROW_CFG)
                cfg_write(row.code, row.value[15:0]);
            else
            begin
                it.opcode    = row.code;
                it.data_byte = row.value[7:0];
                it.pal_index = row.pal_index;
                it.pal_color = row.value;
                put_item(it, row.typed, row.want);
            end
        end

        // fill the whole palette before any random indexed decoding
        send_idle_pct = 0;
        stall_pct     = 0;
        for (n = 0; n < trpd_pkg::PALETTE_DEPTH; n++)
        begin
            it.opcode    = trpd_pkg::OP_PAL_WRITE;
            it.data_byte = 8'($urandom_range(255));
            it.pal_index = 8'(n);
            it.pal_color = 24'($urandom);
            put_item(it, 1'b0, NO_PIXEL);
        end

        for (phase = 0; phase < N_PHASES; phase++)
        begin
            wid = 16'($urandom_range(8, 1));
            hgt = 16'($urandom_range(8, 1));
            case (phase)
                3:
                begin
                    wid = 16'hFFFF;
                    hgt = 16'hFFFF;
                end
                5:  wid = 16'd0;
                9:
                begin
                    wid = 16'd1;
                    hgt = 16'hFFFF;
                end
                13:
                begin
                    wid = 16'hFFFF;
                    hgt = 16'd0;
                end
                default: ;
            endcase
            cfg_write(trpd_pkg::CFG_PIXEL_FORMAT, {13'd0, PHASE_FORMATS[phase % 8]});
            cfg_write(trpd_pkg::CFG_IMAGE_WIDTH, wid);
            cfg_write(trpd_pkg::CFG_IMAGE_HEIGHT, hgt);
            case (phase % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 64;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 64;
                end
                default:
                begin
                    send_idle_pct = 35;
                    stall_pct     = 35;
                end
            endcase
            // long receiver hold while the sender keeps offering gray bytes
            if (phase == 4)
                hold_off_cycles = LONG_HOLD;

            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 6 && n == ITEMS_PER_PHASE / 2)
                    wait_idle();
                roll         = $urandom_range(99);
                it.pal_index = 8'($urandom_range(255));
                it.pal_color = 24'($urandom);
                it.data_byte = 8'($urandom_range(255));
                if (roll < 5)
                    it.opcode = trpd_pkg::OP_PAL_WRITE;
                else if (roll < 8)
                    it.opcode = trpd_pkg::OP_RESTART;
                else if (roll < 10)
                    it.opcode = OP_UNUSED;
                else
                begin
                    it.opcode = trpd_pkg::OP_STREAM;
                    // mostly short runs so images complete often
                    if (await_header && $urandom_range(1) != 0)
                        it.data_byte[6:0] = 7'($urandom_range(7));
                end
                put_item(it, 1'b0, NO_PIXEL);
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
